// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the dual wheel speed controller.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/dwsp_pkg.sv =====
// Shared types and constants of the dual wheel speed PI controller.
// Depends on nothing; used by dwsp_wheel and dual_wheel_speed_pi.
package dwsp_pkg;

    localparam int GAIN_W   = 16;
    localparam int DUTY_W   = 15;
    localparam int ERR_W    = 14;
    localparam int DRIVE_W  = 16;
    localparam int REG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam int ERR_MAX = 8191;

    localparam logic [GAIN_W-1:0] KP_RESET         = 16'd512;
    localparam logic [GAIN_W-1:0] KI_RESET         = 16'd512;
    localparam logic [DUTY_W-1:0] DUTY_LIMIT_RESET = 15'd12800;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_KP         = 2'd0,
        REG_KI         = 2'd1,
        REG_DUTY_LIMIT = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [GAIN_W-1:0] kp;
        logic [GAIN_W-1:0] ki;
        logic [DUTY_W-1:0] duty_limit;
    } dwsp_cfg_t;

endpackage

// ===== rtl/dwsp_wheel.sv =====
// One wheel of the incremental PI controller: error, increment, clamped drive.
// Depends on dwsp_pkg; holds the last error and drive state of its wheel.
module dwsp_wheel #(
    parameter int COUNT_WIDTH = 13
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          update,
    input  dwsp_pkg::dwsp_cfg_t           cfg,
    input  logic signed [COUNT_WIDTH-1:0] target,
    input  logic signed [COUNT_WIDTH:0]   count,
    output logic [dwsp_pkg::DUTY_W-1:0]   fwd_duty,
    output logic [dwsp_pkg::DUTY_W-1:0]   rev_duty
);

    localparam int DIFF_W = COUNT_WIDTH + 2;
    localparam int CMP_W  = (DIFF_W > dwsp_pkg::ERR_W + 1) ? DIFF_W : dwsp_pkg::ERR_W + 1;
    localparam int ERR_W  = dwsp_pkg::ERR_W;
    localparam int DRV_W  = dwsp_pkg::DRIVE_W;
    localparam int PROD_W = 32;
    localparam int SUM_W  = 33;

    localparam logic signed [CMP_W-1:0] ERR_HI = CMP_W'(dwsp_pkg::ERR_MAX);
    localparam logic signed [CMP_W-1:0] ERR_LO = -ERR_HI;

    logic signed [ERR_W-1:0]  last_err_reg;
    logic signed [DRV_W-1:0]  drive_reg;
    logic signed [ERR_W-1:0]  last_err_next;
    logic signed [DRV_W-1:0]  drive_next;

    logic signed [DIFF_W-1:0] diff;
    logic signed [CMP_W-1:0]  diff_ext;
    logic signed [ERR_W:0]    delta;
    logic signed [PROD_W-1:0] p_prod;
    logic signed [PROD_W-1:0] i_prod;
    logic signed [SUM_W-1:0]  d_sum;
    logic signed [SUM_W-1:0]  lim_pos;
    logic signed [SUM_W-1:0]  lim_neg;
    logic signed [SUM_W-1:0]  d_clamp;
    logic signed [DRV_W-1:0]  drive_neg;

    always_comb begin
        diff     = {{2{target[COUNT_WIDTH-1]}}, target} - {count[COUNT_WIDTH], count};
        diff_ext = CMP_W'(diff);
        if (diff_ext > ERR_HI) begin
            last_err_next = ERR_W'(ERR_HI);
        end else if (diff_ext < ERR_LO) begin
            last_err_next = ERR_W'(ERR_LO);
        end else begin
            last_err_next = diff_ext[ERR_W-1:0];
        end

        delta  = {last_err_next[ERR_W-1], last_err_next} - {last_err_reg[ERR_W-1], last_err_reg};
        // Products fit in 31 bits, so a 32-bit signed result is exact.
        p_prod = $signed({{(PROD_W-dwsp_pkg::GAIN_W){1'b0}}, cfg.kp})
               * $signed({{(PROD_W-ERR_W-1){delta[ERR_W]}}, delta});
        i_prod = $signed({{(PROD_W-dwsp_pkg::GAIN_W){1'b0}}, cfg.ki})
               * $signed({{(PROD_W-ERR_W){last_err_next[ERR_W-1]}}, last_err_next});

        d_sum = {p_prod[PROD_W-1], p_prod} + {i_prod[PROD_W-1], i_prod}
              + {{(SUM_W-DRV_W){drive_reg[DRV_W-1]}}, drive_reg};

        lim_pos = {{(SUM_W-dwsp_pkg::DUTY_W){1'b0}}, cfg.duty_limit};
        lim_neg = -lim_pos;
        if (d_sum > lim_pos) begin
            d_clamp = lim_pos;
        end else if (d_sum < lim_neg) begin
            d_clamp = lim_neg;
        end else begin
            d_clamp = d_sum;
        end
        drive_next = d_clamp[DRV_W-1:0];
        drive_neg  = -drive_next;

        // A zero drive takes the reverse branch, which gives zero on both sides.
        if (drive_next > 0) begin
            fwd_duty = drive_next[dwsp_pkg::DUTY_W-1:0];
            rev_duty = '0;
        end else begin
            fwd_duty = '0;
            rev_duty = drive_neg[dwsp_pkg::DUTY_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_err_reg <= '0;
            drive_reg    <= '0;
        end else if (update) begin
            last_err_reg <= last_err_next;
            drive_reg    <= drive_next;
        end
    end

endmodule

// ===== rtl/dual_wheel_speed_pi.sv =====
// Top level of the dual wheel incremental PI speed controller.
// Depends on dwsp_pkg, dwsp_wheel and assert_macros.svh.
//
//  Channel   Direction  Ports                         Contents
//  input     slave      s_tvalid s_tready s_tdata     two counts and two targets
//                       s_tuser                       stop flag
//  result    master     m_tvalid m_tready m_tdata     four H-bridge duties
//  config    write      cfg_wr_en cfg_index cfg_wdata kp, ki, duty_limit
//
// An accepted beat waits in the input register for a free result register;
// the wheel logic then writes the result register and the wheel state in the
// same edge. One beat is taken every cycle unless the result stalls; the only
// loop is the per-wheel drive and last-error update, closed by the wheel state.
// A stalled result holds the output register, and the input register still
// takes one more beat behind it. Reset is synchronous and active low; it
// restores the register defaults and clears the wheel state.
`include "assert_macros.svh"

module dual_wheel_speed_pi #(
    parameter int COUNT_WIDTH = 13,
    localparam int S_TDATA_W = ((4 * COUNT_WIDTH + 7) / 8) * 8,
    localparam int M_TDATA_W = ((4 * dwsp_pkg::DUTY_W + 7) / 8) * 8
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Input channel.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // s_tdata from bit 0: left_count, right_count, left_target, right_target.
    input  logic [S_TDATA_W-1:0]              s_tdata,
    // s_tuser: stop.
    input  logic                              s_tuser,
    // Result channel.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // m_tdata from bit 0: left_forward_duty, left_reverse_duty,
    // right_forward_duty, right_reverse_duty.
    output logic [M_TDATA_W-1:0]              m_tdata,
    // Configuration write port.
    input  logic                              cfg_wr_en,
    input  logic [dwsp_pkg::REG_IDX_W-1:0]    cfg_index,
    input  logic [dwsp_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    localparam int CW = COUNT_WIDTH;
    localparam int DW = dwsp_pkg::DUTY_W;

    // Configuration registers.
    dwsp_pkg::dwsp_cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.kp         <= dwsp_pkg::KP_RESET;
            cfg_reg.ki         <= dwsp_pkg::KI_RESET;
            cfg_reg.duty_limit <= dwsp_pkg::DUTY_LIMIT_RESET;
        end else if (cfg_wr_en) begin
            unique case (dwsp_pkg::reg_idx_t'(cfg_index))
                dwsp_pkg::REG_KP:         cfg_reg.kp <= cfg_wdata;
                dwsp_pkg::REG_KI:         cfg_reg.ki <= cfg_wdata;
                dwsp_pkg::REG_DUTY_LIMIT: cfg_reg.duty_limit <= cfg_wdata[DW-1:0];
                default: ;
            endcase
        end
    end

    // Pipeline control: input register feeds the result register directly.
    logic in_vld_reg;
    logic out_vld_reg;
    logic out_free;
    logic advance;

    logic signed [CW-1:0] lc_reg;
    logic signed [CW-1:0] rc_reg;
    logic signed [CW-1:0] lt_reg;
    logic signed [CW-1:0] rt_reg;
    logic                 stop_reg;

    assign out_free = !out_vld_reg || m_tready;
    assign advance  = in_vld_reg && out_free;
    assign s_tready = !in_vld_reg || out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_tready) begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            lc_reg   <= s_tdata[CW-1:0];
            rc_reg   <= s_tdata[2*CW-1:CW];
            lt_reg   <= s_tdata[3*CW-1:2*CW];
            rt_reg   <= s_tdata[4*CW-1:3*CW];
            stop_reg <= s_tuser;
        end
    end

    // The right encoder turns the other way, so its count is negated here.
    // The stop flag zeroes both targets.
    logic signed [CW:0]   lc_ext;
    logic signed [CW:0]   rc_neg;
    logic signed [CW-1:0] lt_eff;
    logic signed [CW-1:0] rt_eff;

    assign lc_ext = {lc_reg[CW-1], lc_reg};
    assign rc_neg = -{rc_reg[CW-1], rc_reg};
    assign lt_eff = stop_reg ? '0 : lt_reg;
    assign rt_eff = stop_reg ? '0 : rt_reg;

    logic [DW-1:0] l_fwd;
    logic [DW-1:0] l_rev;
    logic [DW-1:0] r_fwd;
    logic [DW-1:0] r_rev;

    dwsp_wheel #(.COUNT_WIDTH(COUNT_WIDTH)) u_left (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .update   (advance),
        .cfg      (cfg_reg),
        .target   (lt_eff),
        .count    (lc_ext),
        .fwd_duty (l_fwd),
        .rev_duty (l_rev)
    );

    dwsp_wheel #(.COUNT_WIDTH(COUNT_WIDTH)) u_right (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .update   (advance),
        .cfg      (cfg_reg),
        .target   (rt_eff),
        .count    (rc_neg),
        .fwd_duty (r_fwd),
        .rev_duty (r_rev)
    );

    // Result register.
    logic [DW-1:0] l_fwd_reg;
    logic [DW-1:0] l_rev_reg;
    logic [DW-1:0] r_fwd_reg;
    logic [DW-1:0] r_rev_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (out_free) begin
            out_vld_reg <= in_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            l_fwd_reg <= l_fwd;
            l_rev_reg <= l_rev;
            r_fwd_reg <= r_fwd;
            r_rev_reg <= r_rev;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {{(M_TDATA_W - 4 * DW){1'b0}}, r_rev_reg, r_fwd_reg, l_rev_reg, l_fwd_reg};

    // A held input beat moves into a free result register on the next edge.
    `ASSERT_NEXT(a_adv_fills_out, aclk, aresetn, advance, out_vld_reg, "result beat lost")
    // The input side only stalls behind a full, stalled result register.
    `ASSERT_IMPL(a_stall_cause, aclk, aresetn, !s_tready,
                 in_vld_reg && out_vld_reg && !m_tready, "input stalled without cause")
    // A wheel never drives forward and reverse at once.
    `ASSERT_IMPL(a_hbridge_excl, aclk, aresetn, out_vld_reg,
                 (l_fwd_reg == '0 || l_rev_reg == '0) && (r_fwd_reg == '0 || r_rev_reg == '0),
                 "both H-bridge sides active")

endmodule
